// ===== src/binary_matrix_local_alignment_core_assert.svh =====
// Assertion macros used by the alignment core checker
`ifndef BINARY_MATRIX_LOCAL_ALIGNMENT_CORE_ASSERT_SVH
`define BINARY_MATRIX_LOCAL_ALIGNMENT_CORE_ASSERT_SVH

// Condition in one cycle implies consequence in the same cycle
`define BMLA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("alignment core check failed");

// Condition in one cycle implies consequence in the next cycle
`define BMLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("alignment core check failed");

`endif

// ===== src/bmla_pkg.sv =====
// Types, constants and saturating score helpers for the alignment core
`timescale 1ns / 1ps
`default_nettype none

package bmla_pkg;

    typedef logic signed [23:0] score_t;
    typedef logic signed [7:0]  coef_t;
    typedef logic [10:0]        rcount_t;

    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 8;

    localparam score_t SCORE_MAX = 24'sh7FFFFF;
    localparam score_t SCORE_MIN = -24'sh800000;
    localparam logic signed [24:0] WIDE_MAX = 25'sd8388607;
    localparam logic signed [24:0] WIDE_MIN = -25'sd8388608;

    localparam rcount_t ROW_COUNT_RST = 11'd1024;
    localparam coef_t   MATCH_RST     = 8'sd2;
    localparam coef_t   MISMATCH_RST  = -8'sd3;
    localparam coef_t   GAP_RST       = -8'sd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_COUNT = 8'd0,
        REG_MATCH     = 8'd1,
        REG_MISMATCH  = 8'd2,
        REG_GAP       = 8'd3
    } reg_idx_t;

    typedef struct packed {
        logic match_bit;
        logic last_cell;
    } in_t;

    typedef struct packed {
        score_t      cell_score;
        logic [22:0] best_score;
        logic        final_flag;
    } out_t;

    // Per-item control from the row sequencer
    typedef struct packed {
        logic   row_zero;
        logic   first_col;
        score_t left_init;
    } seq_info_t;

    // Clamp a 25-bit sum into the score range
    function automatic score_t sat_score(input logic signed [24:0] v);
        score_t r;
        if (v > WIDE_MAX) begin
            r = SCORE_MAX;
        end
        else if (v < WIDE_MIN) begin
            r = SCORE_MIN;
        end
        else begin
            r = v[23:0];
        end
        return r;
    endfunction

    // Saturating score plus 8-bit coefficient
    function automatic score_t add_sat(input score_t a, input coef_t b);
        logic signed [24:0] s;
        s = 25'(a) + 25'(b);
        return sat_score(s);
    endfunction

endpackage

`default_nettype wire

// ===== src/bmla_seq.sv =====
// Row sequencer: row index, first-column flag and column-0 boundary value
`timescale 1ns / 1ps
`default_nettype none

module bmla_seq
    import bmla_pkg::*;
#(
    parameter int MAX_ROWS = 1024
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   accept,
    input  wire logic                   last_cell,
    input  wire rcount_t                row_count,
    input  wire coef_t                  gap_score,
    output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] addr,
    output seq_info_t                   info
);

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = $clog2(MAX_ROWS + 1);
    localparam int EW = (CW > 11) ? CW : 11;
    localparam int PW = CW + 9;
    localparam int SW = (PW > 25) ? PW : 25;
    localparam logic [EW-1:0] ROWS_MAX = EW'(MAX_ROWS);
    localparam logic signed [SW-1:0] LIM_HI = SW'(SCORE_MAX);
    localparam logic signed [SW-1:0] LIM_LO = SW'(SCORE_MIN);

    logic [AW-1:0]          row_index_reg;
    logic                   first_col_reg;
    logic [EW-1:0]          rows_eff;
    logic [EW-1:0]          row_count_x;
    logic [AW-1:0]          r_sel;
    logic [EW-1:0]          r_inc;
    logic                   col_end;
    logic signed [PW-1:0]   prod;
    logic signed [SW-1:0]   prod_x;

    // Clamp the row count into 1..MAX_ROWS
    assign row_count_x = EW'(row_count);
    always_comb
    begin
        if (row_count_x == '0) begin
            rows_eff = EW'(1);
        end
        else if (row_count_x > ROWS_MAX) begin
            rows_eff = ROWS_MAX;
        end
        else begin
            rows_eff = row_count_x;
        end
    end

    // Wrap a row index left past a lowered count
    assign r_sel   = (EW'(row_index_reg) >= rows_eff) ? '0 : row_index_reg;
    assign r_inc   = EW'(r_sel) + EW'(1);
    assign col_end = (r_inc >= rows_eff);

    // Column-0 boundary: (row + 1) * gap, saturated
    assign prod   = $signed({1'b0, r_inc[CW-1:0]}) * gap_score;
    assign prod_x = SW'(prod);

    always_comb
    begin
        info.row_zero  = (r_sel == '0);
        info.first_col = first_col_reg;
        if (prod_x > LIM_HI) begin
            info.left_init = SCORE_MAX;
        end
        else if (prod_x < LIM_LO) begin
            info.left_init = SCORE_MIN;
        end
        else begin
            info.left_init = prod_x[23:0];
        end
    end

    assign addr = r_sel;

    // Advance the row on each accepted word; restart after the last cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            row_index_reg <= '0;
            first_col_reg <= 1'b1;
        end
        else if (accept) begin
            if (last_cell) begin
                row_index_reg <= '0;
                first_col_reg <= 1'b1;
            end
            else if (col_end) begin
                row_index_reg <= '0;
                first_col_reg <= 1'b0;
            end
            else begin
                row_index_reg <= r_inc[AW-1:0];
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/bmla_cell.sv =====
// Cell update: max of zero, above, left and diagonal, plus running best
`timescale 1ns / 1ps
`default_nettype none

module bmla_cell
    import bmla_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   advance,
    input  wire logic   match_bit,
    input  wire logic   last_cell,
    input  wire logic   row_zero,
    input  wire score_t left_score,
    input  wire coef_t  match_score,
    input  wire coef_t  mismatch_score,
    input  wire coef_t  gap_score,
    output score_t      cell_score,
    output logic [22:0] best_score
);

    score_t boundary_reg;
    score_t above_reg;
    score_t diag_reg;
    score_t best_reg;

    score_t boundary_next;
    score_t above_cur;
    score_t diag_base;
    score_t up_val;
    score_t diag_val;
    score_t left_val;
    score_t cell_val;
    score_t best_next;

    // Form the three candidates and take the maximum, floored at zero
    always_comb
    begin
        boundary_next = add_sat(boundary_reg, gap_score);
        above_cur     = row_zero ? boundary_next : above_reg;
        diag_base     = row_zero ? boundary_reg : diag_reg;
        up_val        = add_sat(above_cur, gap_score);
        diag_val      = add_sat(diag_base, match_bit ? match_score : mismatch_score);
        left_val      = add_sat(left_score, gap_score);
        cell_val      = left_val;
        if (up_val > cell_val) begin
            cell_val = up_val;
        end
        if (diag_val > cell_val) begin
            cell_val = diag_val;
        end
        if (cell_val[23]) begin
            cell_val = '0;
        end
        best_next = (cell_val > best_reg) ? cell_val : best_reg;
    end

    assign cell_score = cell_val;
    assign best_score = best_next[22:0];

    // Hold neighbor scores; drop all of them after the last cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            boundary_reg <= '0;
            above_reg    <= '0;
            diag_reg     <= '0;
            best_reg     <= '0;
        end
        else if (advance) begin
            if (last_cell) begin
                boundary_reg <= '0;
                above_reg    <= '0;
                diag_reg     <= '0;
                best_reg     <= '0;
            end
            else begin
                if (row_zero) begin
                    boundary_reg <= boundary_next;
                end
                above_reg <= cell_val;
                diag_reg  <= left_score;
                best_reg  <= best_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/binary_matrix_local_alignment_core.sv =====
// Top level of the binary match matrix local alignment core
// Takes one matrix bit per cycle unless a result word is stalled, column-major with rows
// fastest, and returns one word per bit: the cell score, the running best and a final flag
// copied from last_cell. Sustained rate is one word per clock while out_ready is held; an
// accepted input passes the issue register, then the result register, before its result
// is presented. The previous column sits in a MAX_ROWS x 24 memory that is read at the row
// index when a word is accepted and written when the cell completes; a same-row write in
// flight is forwarded, so single-row matrices also run at full rate. The memory is not
// cleared; a column longer than the one before it reads stale data. Registers must be
// written by the user only while the core is idle; the core itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module binary_matrix_local_alignment_core
    import bmla_pkg::*;
#(
    parameter int MAX_ROWS = 1024
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire in_t                   in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output out_t                       out_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    rcount_t     row_count_reg;
    coef_t       match_reg;
    coef_t       mismatch_reg;
    coef_t       gap_reg;

    logic        s_vld_reg;
    logic        o_vld_reg;
    in_t         iss_word_reg;
    seq_info_t   iss_info_reg;
    logic [AW-1:0] iss_addr_reg;
    score_t      rd_data_reg;
    logic        byp_hit_reg;
    score_t      byp_data_reg;
    out_t        out_reg;

    score_t      col_mem [0:MAX_ROWS-1];

    logic        accept;
    logic        s_move;
    logic [AW-1:0] seq_addr;
    seq_info_t   seq_info;
    score_t      left_sel;
    score_t      cell_score;
    logic [22:0] best_score;

    // Handshake: the result register parts input from output
    assign s_move    = s_vld_reg && (!o_vld_reg || out_ready);
    assign in_ready  = !s_vld_reg || s_move;
    assign accept    = in_valid && in_ready;
    assign out_valid = o_vld_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            row_count_reg <= ROW_COUNT_RST;
            match_reg     <= MATCH_RST;
            mismatch_reg  <= MISMATCH_RST;
            gap_reg       <= GAP_RST;
        end
        else if (cfg_valid) begin
            case (cfg_index)
                REG_ROW_COUNT: row_count_reg <= cfg_data;
                REG_MATCH:     match_reg     <= cfg_data[7:0];
                REG_MISMATCH:  mismatch_reg  <= cfg_data[7:0];
                REG_GAP:       gap_reg       <= cfg_data[7:0];
                default:       ;
            endcase
        end
    end

    bmla_seq #(
        .MAX_ROWS (MAX_ROWS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .last_cell (in_data.last_cell),
        .row_count (row_count_reg),
        .gap_score (gap_reg),
        .addr      (seq_addr),
        .info      (seq_info)
    );

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else begin
            if (accept) begin
                s_vld_reg <= 1'b1;
            end
            else if (s_move) begin
                s_vld_reg <= 1'b0;
            end
            if (s_move) begin
                o_vld_reg <= 1'b1;
            end
            else if (out_ready) begin
                o_vld_reg <= 1'b0;
            end
        end
    end

    // Column memory: write the finished cell, read ahead for the accepted word
    always_ff @(posedge clk)
    begin
        if (s_move) begin
            col_mem[iss_addr_reg] <= cell_score;
        end
        if (accept) begin
            rd_data_reg <= col_mem[seq_addr];
        end
    end

    // Issue register with forwarding of a same-row write
    always_ff @(posedge clk)
    begin
        if (accept) begin
            iss_word_reg <= in_data;
            iss_info_reg <= seq_info;
            iss_addr_reg <= seq_addr;
            byp_hit_reg  <= s_move && (iss_addr_reg == seq_addr);
            byp_data_reg <= cell_score;
        end
    end

    assign left_sel = iss_info_reg.first_col ? iss_info_reg.left_init :
                      (byp_hit_reg ? byp_data_reg : rd_data_reg);

    bmla_cell u_cell (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (s_move),
        .match_bit      (iss_word_reg.match_bit),
        .last_cell      (iss_word_reg.last_cell),
        .row_zero       (iss_info_reg.row_zero),
        .left_score     (left_sel),
        .match_score    (match_reg),
        .mismatch_score (mismatch_reg),
        .gap_score      (gap_reg),
        .cell_score     (cell_score),
        .best_score     (best_score)
    );

    // Result register
    always_ff @(posedge clk)
    begin
        if (s_move) begin
            out_reg.cell_score <= cell_score;
            out_reg.best_score <= best_score;
            out_reg.final_flag <= iss_word_reg.last_cell;
        end
    end

endmodule

`default_nettype wire

// ===== src/bmla_checker.sv =====
// Port-level checker for the alignment core and its bind
`timescale 1ns / 1ps
`default_nettype none

`include "binary_matrix_local_alignment_core_assert.svh"

module bmla_checker
    import bmla_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire out_t out_data
);

    // A stalled result word holds
    `BMLA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

    // Cell scores are floored at zero
    `BMLA_ASSERT_NOW(a_cell_nonneg, clk, rst_n, out_valid, !out_data.cell_score[23])

    // The running best covers the current cell
    `BMLA_ASSERT_NOW(a_best_covers, clk, rst_n, out_valid, out_data.best_score >= out_data.cell_score[22:0])

    // Input stalls only behind a stuck result word
    `BMLA_ASSERT_NOW(a_stall_cause, clk, rst_n, !in_ready, out_valid && !out_ready)

endmodule

bind binary_matrix_local_alignment_core bmla_checker u_bmla_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
